@@ hdl/hsv2rgb_pkg.sv @@
// Shared types and constants for the HSV to RGB converter.
package hsv2rgb_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam logic [CHANNEL_BITS-1:0] CH_MAX = '1;

    localparam int HUE_BITS = 9;
    localparam int PCT_BITS = 7;

    // Channel numerators are scaled by a common denominator of 600000.
    localparam int DENOM    = 600000;
    localparam int DIV2     = 2 * DENOM;
    localparam int NUM_BITS = 20;

    // Rounded numerator 2*MAX*num + DENOM stays below 2^(CHANNEL_BITS + 21).
    localparam int N_BITS    = CHANNEL_BITS + 21;
    // Reciprocal of DIV2: exact for every N below 2^N_BITS since DIV2 < 2^21.
    localparam int REC_SHIFT = N_BITS + 21;
    localparam int K_BITS    = REC_SHIFT - 20;
    localparam longint unsigned REC_K_FULL =
        ((64'd1 << REC_SHIFT) + 64'(DIV2) - 64'd1) / 64'(DIV2);
    localparam logic [K_BITS-1:0] REC_K = K_BITS'(REC_K_FULL);
    localparam int PROD_BITS = N_BITS + K_BITS;

    typedef struct packed {
        logic [HUE_BITS-1:0] hue;
        logic [PCT_BITS-1:0] saturation;
        logic [PCT_BITS-1:0] brightness;
    } t_hsv_req;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
        logic                    out_of_range;
    } t_rgb_res;

endpackage

@@ hdl/hsv_to_rgb_converter.sv @@
// HSV to RGB color converter, six-register pipeline.
//
// Usage:
//   A request (hue in degrees, saturation and brightness in percent) is taken
//   on i_req at a rising edge where start is high and busy is low. busy is
//   always low: the pipeline takes a new request every clock cycle.
//   Each result appears on o_res for exactly one cycle with o_valid high,
//   after passing through the registers of stages A to E and the output
//   register. Throughput is one result per cycle.
//   Stages: range check / sextant / s*v, chroma and offset products, scaled
//   numerator, reciprocal multiply (divide by 1200000), output register.
//   The reciprocal multiply is the deepest stage and sets the clock.
//   An input above its range yields white with out_of_range set.
//   The receiver cannot stall, so no back-pressure exists anywhere.
//   Reset (i_rst_n low, synchronous) clears every valid bit; requests in
//   flight are dropped and o_valid is low after the reset edge.
module hsv_to_rgb_converter (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  hsv2rgb_pkg::t_hsv_req  i_req,
    output logic                   o_valid,
    output hsv2rgb_pkg::t_rgb_res  o_res
);

    localparam int CB  = hsv2rgb_pkg::CHANNEL_BITS;
    localparam int NB  = hsv2rgb_pkg::NUM_BITS;
    localparam int NWB = hsv2rgb_pkg::N_BITS;
    localparam int PB  = hsv2rgb_pkg::PROD_BITS;

    // red, green, blue lanes
    localparam int CH_R = 0;
    localparam int CH_G = 1;
    localparam int CH_B = 2;

    typedef enum logic [2:0] {
        SEXT_0 = 3'd0,  // [0,60)    r=c g=x b=0
        SEXT_1 = 3'd1,  // [60,120)  r=x g=c b=0
        SEXT_2 = 3'd2,  // [120,180) r=0 g=c b=x
        SEXT_3 = 3'd3,  // [180,240) r=0 g=x b=c
        SEXT_4 = 3'd4,  // [240,300) r=x g=0 b=c
        SEXT_5 = 3'd5   // [300,360] r=c g=0 b=x
    } t_sextant;

    wire accept = start && !busy;

    // No back-pressure: a request can enter every cycle.
    assign busy = 1'b0;

    // ---------------- Stage A: captured request ----------------
    logic                  r_a_valid;
    hsv2rgb_pkg::t_hsv_req r_a_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_req <= i_req;
        end
    end

    // Range check, hue folded into [0,60], sextant, first products.
    logic       n_b_oor;
    logic [8:0] a_hm;
    logic [8:0] a_fold;
    logic [5:0] n_b_t;
    t_sextant   n_b_sext;
    logic [13:0] n_b_sv;
    logic [13:0] n_b_vd;
    logic [6:0]  a_sinv;

    always_comb begin
        n_b_oor = (r_a_req.hue > 9'd360) || (r_a_req.saturation > 7'd100) ||
                  (r_a_req.brightness > 7'd100);

        // hue mod 120 by compare and subtract, for hue below 360
        if (r_a_req.hue >= 9'd240) begin
            a_hm = r_a_req.hue - 9'd240;
        end else if (r_a_req.hue >= 9'd120) begin
            a_hm = r_a_req.hue - 9'd120;
        end else begin
            a_hm = r_a_req.hue;
        end
        a_fold = (a_hm >= 9'd60) ? (9'd120 - a_hm) : a_hm;
        n_b_t  = a_fold[5:0];

        if (r_a_req.hue < 9'd60) begin
            n_b_sext = SEXT_0;
        end else if (r_a_req.hue < 9'd120) begin
            n_b_sext = SEXT_1;
        end else if (r_a_req.hue < 9'd180) begin
            n_b_sext = SEXT_2;
        end else if (r_a_req.hue < 9'd240) begin
            n_b_sext = SEXT_3;
        end else if (r_a_req.hue < 9'd300) begin
            n_b_sext = SEXT_4;
        end else begin
            n_b_sext = SEXT_5;
        end

        a_sinv = 7'd100 - r_a_req.saturation;
        n_b_sv = 14'(r_a_req.saturation) * 14'(r_a_req.brightness);
        n_b_vd = 14'(r_a_req.brightness) * 14'(a_sinv);
    end

    // ---------------- Stage B ----------------
    logic        r_b_valid;
    logic        r_b_oor;
    logic [5:0]  r_b_t;
    t_sextant    r_b_sext;
    logic [13:0] r_b_sv;
    logic [13:0] r_b_vd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_oor  <= n_b_oor;
        r_b_t    <= n_b_t;
        r_b_sext <= n_b_sext;
        r_b_sv   <= n_b_sv;
        r_b_vd   <= n_b_vd;
    end

    // Chroma, secondary and offset numerators (all over 600000).
    logic [NB-1:0] b_cn;
    logic [NB-1:0] b_xn;
    logic [NB-1:0] b_mn;
    logic [2:0][NB-1:0] b_comp;
    logic [2:0][NB-1:0] n_c_num;

    always_comb begin
        b_cn = NB'(r_b_sv) * NB'(60);
        b_xn = NB'(r_b_sv) * NB'(r_b_t);
        b_mn = NB'(r_b_vd) * NB'(60);

        b_comp = '0;
        unique case (r_b_sext)
            SEXT_0: begin
                b_comp[CH_R] = b_cn;
                b_comp[CH_G] = b_xn;
            end
            SEXT_1: begin
                b_comp[CH_R] = b_xn;
                b_comp[CH_G] = b_cn;
            end
            SEXT_2: begin
                b_comp[CH_G] = b_cn;
                b_comp[CH_B] = b_xn;
            end
            SEXT_3: begin
                b_comp[CH_G] = b_xn;
                b_comp[CH_B] = b_cn;
            end
            SEXT_4: begin
                b_comp[CH_R] = b_xn;
                b_comp[CH_B] = b_cn;
            end
            SEXT_5: begin
                b_comp[CH_R] = b_cn;
                b_comp[CH_B] = b_xn;
            end
            default: begin
                b_comp = '0;
            end
        endcase

        for (int i = 0; i < 3; i++) begin
            n_c_num[i] = b_comp[i] + b_mn;
        end
    end

    // ---------------- Stage C ----------------
    logic               r_c_valid;
    logic               r_c_oor;
    logic [2:0][NB-1:0] r_c_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_oor <= r_b_oor;
        r_c_num <= n_c_num;
    end

    // Round-half-up numerator: 2*MAX*num + DENOM.
    logic [2:0][NWB-1:0] n_d_n;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_d_n[i] = NWB'(r_c_num[i]) * NWB'({hsv2rgb_pkg::CH_MAX, 1'b0}) +
                       NWB'(hsv2rgb_pkg::DENOM);
        end
    end

    // ---------------- Stage D ----------------
    logic                r_d_valid;
    logic                r_d_oor;
    logic [2:0][NWB-1:0] r_d_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_oor <= r_c_oor;
        r_d_n   <= n_d_n;
    end

    // Divide by 1200000 through the reciprocal.
    logic [2:0][PB-1:0] n_e_prod;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_e_prod[i] = PB'(r_d_n[i]) * PB'(hsv2rgb_pkg::REC_K);
        end
    end

    // ---------------- Stage E ----------------
    logic               r_e_valid;
    logic               r_e_oor;
    logic [2:0][PB-1:0] r_e_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else begin
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_oor  <= r_d_oor;
        r_e_prod <= n_e_prod;
    end

    // Quotient bits; white when out of range.
    logic [2:0][CB-1:0]    e_q;
    hsv2rgb_pkg::t_rgb_res n_out;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e_q[i] = r_e_prod[i][hsv2rgb_pkg::REC_SHIFT +: CB];
        end
        if (r_e_oor) begin
            n_out.red   = hsv2rgb_pkg::CH_MAX;
            n_out.green = hsv2rgb_pkg::CH_MAX;
            n_out.blue  = hsv2rgb_pkg::CH_MAX;
        end else begin
            n_out.red   = e_q[CH_R];
            n_out.green = e_q[CH_G];
            n_out.blue  = e_q[CH_B];
        end
        n_out.out_of_range = r_e_oor;
    end

    // ---------------- Output register ----------------
    logic                  r_out_valid;
    hsv2rgb_pkg::t_rgb_res r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    // ---------------- Assertions ----------------
    // every request yields a result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##6 o_valid)
        else $error("result strobe missing after request");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |-> ##6 !o_valid)
        else $error("result strobe without request");

    // hue out of range must reach the flag
    a_hue_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.hue > 9'd360)) |-> ##6 o_res.out_of_range)
        else $error("out-of-range hue not flagged");

    // zero saturation in range gives a gray
    a_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.saturation == 7'd0) && (i_req.hue <= 9'd360) &&
         (i_req.brightness <= 7'd100))
        |-> ##6 ((o_res.red == o_res.green) && (o_res.green == o_res.blue) &&
                 !o_res.out_of_range))
        else $error("zero saturation did not give a gray");

endmodule
